### rtl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants for the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int PIDA_DEPTH  = 64;
  localparam int PIDA_DATA_W = 32;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_DROP   = 3'd3;
  localparam logic [2:0] MODE_DUMP   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_DEL,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [6:0]         entry_count;
    logic signed [31:0] read_value;
    logic               last;
  } result_t;

endpackage

### rtl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered list of signed 32-bit entries with insert, append, delete, drop
// and dump commands, held in a single-port-pair entry memory.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload    direction
//  command   start / busy        cmd        in
//  result    done (strobe)       result     out
//
//  append, drop, rejected commands and unused modes: result in the cycle after
//  the item is taken. insert at p: S_INS moves the entries from p on up, one
//  memory move per cycle, then S_INS_PUT writes the item. delete at p: S_DEL
//  moves the entries after p down. dump: one entry read, one result per cycle.
//  the shifts are bounded by the single read and write port of the memory.
//  rst is synchronous; it clears the count, the state and the strobe.
//  results are never stalled; busy is high while a command is in work.
//
module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int DEPTH = PIDA_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t  state, state_next;
  logic [CW-1:0] count, count_next;
  logic    done_next;
  result_t result_next;
  cmd_t    cmd_q, cmd_q_next;
  logic [AW-1:0] idx, idx_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [PIDA_DATA_W-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic signed [PIDA_DATA_W-1:0] mem_rdata;

  logic accept;
  logic full;
  logic empty;
  logic bad_pos;
  logic dump_last;

  pida_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign bad_pos   = (cmd.position == 7'd0) || (cmd.position > 7'(count));
  assign dump_last = ((7'(idx) + 7'd1) == 7'(count));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    cmd_q  <= cmd_q_next;
    idx    <= idx_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    done_next   = 1'b0;
    result_next = result;
    cmd_q_next  = cmd_q;
    idx_next    = idx;
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = mem_rdata;
    mem_raddr   = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q_next              = cmd;
          result_next.status      = ST_OK;
          result_next.entry_count = 7'(count);
          result_next.read_value  = '0;
          result_next.last        = 1'b1;
          case (cmd.mode)
            MODE_INSERT: begin
              if (full) begin
                result_next.status = ST_FULL;
                done_next          = 1'b1;
              end else if (bad_pos) begin
                result_next.status = ST_BADPOS;
                done_next          = 1'b1;
              end else begin
                // move entries up from the top, starting at count - 1
                mem_raddr  = AW'(count - CW'(1));
                idx_next   = AW'(count);
                state_next = S_INS;
              end
            end
            MODE_APPEND: begin
              if (full) begin
                result_next.status = ST_FULL;
              end else begin
                mem_we                  = 1'b1;
                mem_waddr               = AW'(count);
                mem_wdata               = cmd.item_value;
                count_next              = count + CW'(1);
                result_next.entry_count = 7'(count + CW'(1));
              end
              done_next = 1'b1;
            end
            MODE_DELETE: begin
              if (empty) begin
                result_next.status = ST_EMPTY;
                done_next          = 1'b1;
              end else if (bad_pos) begin
                result_next.status = ST_BADPOS;
                done_next          = 1'b1;
              end else if (cmd.position == 7'(count)) begin
                // last entry: nothing to move
                count_next              = count - CW'(1);
                result_next.entry_count = 7'(count - CW'(1));
                done_next               = 1'b1;
              end else begin
                mem_raddr  = AW'(cmd.position);
                idx_next   = AW'(cmd.position - 7'd1);
                state_next = S_DEL;
              end
            end
            MODE_DROP: begin
              if (empty) begin
                result_next.status = ST_EMPTY;
              end else begin
                count_next              = count - CW'(1);
                result_next.entry_count = 7'(count - CW'(1));
              end
              done_next = 1'b1;
            end
            MODE_DUMP: begin
              if (empty) begin
                result_next.status = ST_EMPTY;
                done_next          = 1'b1;
              end else begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // write idx from idx - 1 while fetching idx - 2
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        mem_raddr = idx - AW'(2);
        idx_next  = idx - AW'(1);
        if (idx == AW'(cmd_q.position)) begin
          state_next = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        mem_we                  = 1'b1;
        mem_waddr               = AW'(cmd_q.position - 7'd1);
        mem_wdata               = cmd_q.item_value;
        count_next              = count + CW'(1);
        result_next.entry_count = 7'(count + CW'(1));
        done_next               = 1'b1;
        state_next              = S_IDLE;
      end

      S_DEL: begin
        // write idx from idx + 1 while fetching idx + 2
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        mem_raddr = idx + AW'(2);
        idx_next  = idx + AW'(1);
        if (7'(idx) == (7'(count) - 7'd2)) begin
          count_next              = count - CW'(1);
          result_next.entry_count = 7'(count - CW'(1));
          done_next               = 1'b1;
          state_next              = S_IDLE;
        end
      end

      S_DUMP: begin
        mem_raddr               = idx + AW'(1);
        idx_next                = idx + AW'(1);
        result_next.status      = ST_OK;
        result_next.entry_count = 7'(count);
        result_next.read_value  = mem_rdata;
        result_next.last        = dump_last;
        done_next               = 1'b1;
        if (dump_last) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.mode == MODE_APPEND) && !full |=> count == $past(count) + CW'(1))
    else $error("append did not grow the count");

  a_not_last_only_dump: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> $past(state) == S_DUMP)
    else $error("non-final result outside a dump");

  a_write_in_work: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_IDLE) || accept)
    else $error("memory write with no command in work");
`endif

endmodule

### rtl/pida_ram.sv
// ----------------------------------------------------------------------------
// pida_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pida_ram
  import pida_pkg::*;
#(
  parameter int DEPTH = PIDA_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [PIDA_DATA_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic signed [PIDA_DATA_W-1:0] rdata
);

  logic signed [PIDA_DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
